FILE: rtl/dsu_pkg.sv
// Shared types and constants for the disjoint-set union table.
// Holds the element word layout, memory request bundle, status and op codes.
// No dependencies.
`default_nettype none

package dsu_pkg;

    localparam int ELEM_W     = 10;
    localparam int SIZE_W     = 11;
    localparam int ELEM_COUNT = 1 << ELEM_W;

    localparam logic [1:0] OP_MAKE  = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_UNION = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_SAME   = 2'd2,
        ST_EXISTS = 2'd3
    } status_t;

    // One table entry: presence, representative, list link, tail and size.
    // Tail and size are meaningful at representatives only.
    typedef struct packed {
        logic              present;
        logic [ELEM_W-1:0] rep;
        logic              nxt_end;
        logic [ELEM_W-1:0] nxt;
        logic [ELEM_W-1:0] tail;
        logic [SIZE_W-1:0] size;
    } dsu_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ELEM_W-1:0] rd_addr;
        logic              wr_en;
        logic [ELEM_W-1:0] wr_addr;
        dsu_word_t         wr_data;
    } dsu_mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/dsu_mem.sv
// Element table memory: one write port, one read port, registered read data.
// Depends on dsu_pkg for the entry layout and the request bundle.
`default_nettype none

module dsu_mem
    import dsu_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic         aclk,
    input  wire dsu_mem_req_t req,
    output dsu_word_t         rdata
);

    localparam int AW = $clog2(DEPTH);

    dsu_word_t mem [DEPTH];
    dsu_word_t rdata_reg;

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/disjoint_set_union_table.sv
// Disjoint-set union table: sequencer, result register and assertions.
// Depends on dsu_pkg and on dsu_mem, which holds one word per element.
//
// Input channel s_*: op (make 0, find 1, union 2), elem_a, elem_b; a transfer
// happens when s_valid and s_ready are both high. Result channel m_*: status,
// rep_value, set_size, one result per input transfer, in order.
// All element state lives in one synchronous memory with registered read data;
// every operation is a sequence of reads, plus writes where it changes the table.
// Steps, input transfer to m_valid (s_ready returns with m_valid, so the
// sequencer works on one item at a time):
//   make, spare op, or elem_a absent for find or union  : read elem_a, result
//   find, or union with elem_b absent or in the same set : one more read, result
//   union that merges : read both representatives, walk the smaller set (one
//   memory read and write per member; this walk sets the worst case), tail, head
// Reset: a clearing pass zeroes all min(NUM_ELEMS, 1024) entries;
//   s_ready stays low until it completes.
// Stall: the result register parts the channels, so a new input is taken
//   while a result waits; the sequencer then holds, with no memory traffic,
//   at the step that would produce the next result until m_ready frees it.
`default_nettype none

module disjoint_set_union_table
    import dsu_pkg::*;
#(
    parameter int NUM_ELEMS = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_op,
    input  wire logic [9:0]    s_elem_a,
    input  wire logic [9:0]    s_elem_b,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_status,
    output logic [9:0]         m_rep_value,
    output logic [10:0]        m_set_size
);

    // Only element indices below 1024 can ever be stored.
    localparam int          DEPTH   = (NUM_ELEMS < ELEM_COUNT) ? NUM_ELEMS : ELEM_COUNT;
    localparam int          AW      = $clog2(DEPTH);
    localparam logic [16:0] NUM_LIM = 17'(NUM_ELEMS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_DATA,
        S_R_DATA,
        S_B_DATA,
        S_RA_DATA,
        S_RB_DATA,
        S_WALK,
        S_TAIL,
        S_HEAD
    } state_t;

    function automatic logic in_table(input logic [ELEM_W-1:0] e);
        return 17'(e) < NUM_LIM;
    endfunction

    function automatic logic [ELEM_W-1:0] rep_checked(input logic [ELEM_W-1:0] e,
                                                      input dsu_word_t w);
        return in_table(w.rep) ? w.rep : e;
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [1:0]        op_reg, op_next;
    logic [ELEM_W-1:0] a_reg, a_next;
    logic [ELEM_W-1:0] b_reg, b_next;
    logic              a_in_reg, a_in_next;
    logic              b_in_reg, b_in_next;
    logic [ELEM_W-1:0] ra_reg, ra_next;
    logic [ELEM_W-1:0] rb_reg, rb_next;
    dsu_word_t         wa_reg, wa_next;
    logic [ELEM_W-1:0] small_reg, small_next;
    logic [ELEM_W-1:0] large_reg, large_next;
    dsu_word_t         lw_reg, lw_next;
    logic [ELEM_W-1:0] stail_reg, stail_next;
    logic [SIZE_W-1:0] ssize_reg, ssize_next;
    logic [ELEM_W-1:0] cur_reg, cur_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [ELEM_W-1:0] m_rep_reg, m_rep_next;
    logic [SIZE_W-1:0] m_size_reg, m_size_next;

    dsu_mem_req_t mem_req;
    dsu_word_t    rdata;

    dsu_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rdata(rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_rep_value = m_rep_reg;
    assign m_set_size  = m_size_reg;

    always_comb begin
        logic              emit;
        status_t           e_status;
        logic [ELEM_W-1:0] e_rep;
        logic [SIZE_W-1:0] e_size;
        logic [ELEM_W-1:0] rb;
        logic [SIZE_W-1:0] new_size;
        dsu_word_t         w;

        emit         = 1'b0;
        e_status     = ST_ABSENT;
        e_rep        = '0;
        e_size       = '0;
        rb           = '0;
        new_size     = '0;
        w            = rdata;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a_in_next    = a_in_reg;
        b_in_next    = b_in_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        wa_next      = wa_reg;
        small_next   = small_reg;
        large_next   = large_reg;
        lw_next      = lw_reg;
        stail_next   = stail_reg;
        ssize_next   = ssize_reg;
        cur_next     = cur_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // Zero one entry a cycle; present drops to 0 everywhere.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ELEM_W'(clr_cnt_reg);
                mem_req.wr_data = '0;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_op;
                    a_next          = s_elem_a;
                    b_next          = s_elem_b;
                    a_in_next       = in_table(s_elem_a);
                    b_in_next       = in_table(s_elem_b);
                    mem_req.rd_en   = in_table(s_elem_a);
                    mem_req.rd_addr = s_elem_a;
                    state_next      = S_A_DATA;
                end
            end
            S_A_DATA: begin
                unique case (op_reg) inside
                    OP_MAKE: begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (!a_in_reg) begin
                            e_status = ST_ABSENT;
                        end else if (rdata.present) begin
                            e_status = ST_EXISTS;
                        end else begin
                            w.present       = 1'b1;
                            w.rep           = a_reg;
                            w.nxt_end       = 1'b1;
                            w.nxt           = '0;
                            w.tail          = a_reg;
                            w.size          = SIZE_W'(1);
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = a_reg;
                            mem_req.wr_data = w;
                            e_status        = ST_OK;
                            e_rep           = a_reg;
                            e_size          = SIZE_W'(1);
                        end
                    end
                    OP_FIND, OP_UNION: begin
                        if (!(a_in_reg && rdata.present)) begin
                            emit       = 1'b1;
                            e_status   = ST_ABSENT;
                            state_next = S_IDLE;
                        end else begin
                            ra_next = rep_checked(a_reg, rdata);
                            if (op_reg == OP_FIND) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = rep_checked(a_reg, rdata);
                                state_next      = S_R_DATA;
                            end else begin
                                mem_req.rd_en   = b_in_reg;
                                mem_req.rd_addr = b_reg;
                                state_next      = S_B_DATA;
                            end
                        end
                    end
                    default: begin
                        emit       = 1'b1;
                        e_status   = ST_ABSENT;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_R_DATA: begin
                emit       = 1'b1;
                e_status   = ST_OK;
                e_rep      = ra_reg;
                e_size     = rdata.size;
                state_next = S_IDLE;
            end
            S_B_DATA: begin
                rb = rep_checked(b_reg, rdata);
                if (!(b_in_reg && rdata.present)) begin
                    emit       = 1'b1;
                    e_status   = ST_ABSENT;
                    state_next = S_IDLE;
                end else if (rb == ra_reg) begin
                    emit       = 1'b1;
                    e_status   = ST_SAME;
                    state_next = S_IDLE;
                end else begin
                    rb_next         = rb;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ra_reg;
                    state_next      = S_RA_DATA;
                end
            end
            S_RA_DATA: begin
                wa_next         = rdata;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = rb_reg;
                state_next      = S_RB_DATA;
            end
            S_RB_DATA: begin
                // B's set survives unless it is strictly smaller.
                if (rdata.size < wa_reg.size) begin
                    large_next = ra_reg;
                    lw_next    = wa_reg;
                    small_next = rb_reg;
                    stail_next = in_table(rdata.tail) ? rdata.tail : rb_reg;
                    ssize_next = rdata.size;
                    cur_next   = rb_reg;
                    mem_req.rd_addr = rb_reg;
                end else begin
                    large_next = rb_reg;
                    lw_next    = rdata;
                    small_next = ra_reg;
                    stail_next = in_table(wa_reg.tail) ? wa_reg.tail : ra_reg;
                    ssize_next = wa_reg.size;
                    cur_next   = ra_reg;
                    mem_req.rd_addr = ra_reg;
                end
                mem_req.rd_en = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK: begin
                // Relabel the current member and fetch the next one.
                w.rep           = large_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                mem_req.wr_data = w;
                if (!rdata.nxt_end && in_table(rdata.nxt)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rdata.nxt;
                    cur_next        = rdata.nxt;
                end else if (in_table(lw_reg.tail)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = lw_reg.tail;
                    state_next      = S_TAIL;
                end else begin
                    state_next = S_HEAD;
                end
            end
            S_TAIL: begin
                // Append the smaller list after the larger set's tail.
                w.nxt_end       = 1'b0;
                w.nxt           = small_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = lw_reg.tail;
                mem_req.wr_data = w;
                state_next      = S_HEAD;
            end
            S_HEAD: begin
                new_size = SIZE_W'(lw_reg.size + ssize_reg);
                w        = lw_reg;
                w.tail   = stail_reg;
                w.size   = new_size;
                if (lw_reg.tail == large_reg) begin
                    w.nxt_end = 1'b0;
                    w.nxt     = small_reg;
                end
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = large_reg;
                mem_req.wr_data = w;
                emit            = 1'b1;
                e_status        = ST_OK;
                e_rep           = large_reg;
                e_size          = new_size;
                state_next      = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Hold a result-producing step whole while the result register is still occupied.
        if (emit && m_valid_reg && !m_ready) begin
            emit         = 1'b0;
            state_next   = state_reg;
            ra_next      = ra_reg;
            rb_next      = rb_reg;
            mem_req      = '0;
        end

        m_valid_next  = emit ? 1'b1 : (m_valid_reg && !m_ready);
        m_status_next = emit ? e_status : m_status_reg;
        m_rep_next    = emit ? e_rep : m_rep_reg;
        m_size_next   = emit ? e_size : m_size_reg;
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        a_in_reg     <= a_in_next;
        b_in_reg     <= b_in_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        wa_reg       <= wa_next;
        small_reg    <= small_next;
        large_reg    <= large_next;
        lw_reg       <= lw_next;
        stail_reg    <= stail_next;
        ssize_reg    <= ssize_next;
        cur_reg      <= cur_next;
        m_status_reg <= m_status_next;
        m_rep_reg    <= m_rep_next;
        m_size_reg   <= m_size_next;
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    // The walk never touches the surviving representative's entry.
    a_walk_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> mem_req.wr_addr != large_reg)
        else $error("walk writes the surviving representative");

    // Every member reached by the walk still belongs to the smaller set.
    a_walk_member: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> rdata.present && rdata.rep != large_reg)
        else $error("walk reached an entry outside the smaller set");

    // A find reads back a present representative.
    a_find_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_R_DATA |-> rdata.present && rdata.rep == ra_reg)
        else $error("find read a non-representative entry");

    // A new result appears only after a step that produces one.
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_A_DATA || $past(state_reg) == S_R_DATA
                            || $past(state_reg) == S_B_DATA || $past(state_reg) == S_HEAD))
        else $error("result produced from a non-emitting step");

    // No memory traffic while the S_R_DATA or S_HEAD step waits on the result register.
    a_stall_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && (state_reg == S_R_DATA || state_reg == S_HEAD))
            |-> !mem_req.wr_en && !mem_req.rd_en)
        else $error("memory accessed during a result stall");
`endif

endmodule

`default_nettype wire
